// ===== hw/rtl/ffrc_pkg.sv =====
package ffrc_pkg;

    // Lane geometry
    localparam int LANE_COUNT = 8;
    localparam int LANE_W     = 32;
    localparam int MODE_W     = 3;

    // Conversion modes; codes 5 to 7 fall through to raw copy
    typedef enum logic [MODE_W-1:0] {
        MODE_COPY      = 3'd0,
        MODE_F32_BF16  = 3'd1,
        MODE_F32_FP16  = 3'd2,
        MODE_BF16_FP16 = 3'd3,
        MODE_FP16_BF16 = 3'd4
    } t_mode;

    typedef logic [LANE_W-1:0] t_lane;

    // Exponent limits on an 8-bit biased source exponent (bias 127).
    // At or below 112 the fp16 exponent would be <= 0; above 143 it overflows.
    localparam logic [7:0] EXP_REBIAS  = 8'd112;
    localparam logic [7:0] EXP_SRC_MAX = 8'd143;

endpackage

// ===== hw/rtl/float_format_row_converter.sv =====
// Eight-lane float format converter. A word is taken at every clock edge where
// start is high and busy is low; busy is low whenever reset is released, so one
// word can enter each cycle. The result passes through the input register and then
// the result register, and is shown for exactly one cycle with o_done high; the
// receiver cannot stall it and must capture it in that cycle. The lane conversion
// is a single pass of shallow mask, shift, add and compare logic between the two
// registers, so throughput is one word per cycle. The mode register is written
// through the cfg channel (always ready) and should only change while no word is
// in flight. 16-bit results sit in the low half of each lane with the upper half
// zero.
module float_format_row_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_lane0_in,
    input  logic [31:0] i_lane1_in,
    input  logic [31:0] i_lane2_in,
    input  logic [31:0] i_lane3_in,
    input  logic [31:0] i_lane4_in,
    input  logic [31:0] i_lane5_in,
    input  logic [31:0] i_lane6_in,
    input  logic [31:0] i_lane7_in,
    input  logic        i_row_end_in,
    output logic        o_done,
    output logic [31:0] o_lane0_out,
    output logic [31:0] o_lane1_out,
    output logic [31:0] o_lane2_out,
    output logic [31:0] o_lane3_out,
    output logic [31:0] o_lane4_out,
    output logic [31:0] o_lane5_out,
    output logic [31:0] o_lane6_out,
    output logic [31:0] o_lane7_out,
    output logic        o_row_end_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);

    logic                        accept;
    logic [ffrc_pkg::MODE_W-1:0] r_mode;
    logic                        r_in_vld;
    logic                        r_in_row_end;
    ffrc_pkg::t_lane             r_in_lane [ffrc_pkg::LANE_COUNT];
    ffrc_pkg::t_lane             n_res_lane [ffrc_pkg::LANE_COUNT];
    ffrc_pkg::t_lane             r_res_lane [ffrc_pkg::LANE_COUNT];
    ffrc_pkg::t_lane             in_lane [ffrc_pkg::LANE_COUNT];
    logic                        r_res_vld;
    logic                        r_res_row_end;

    // Handshake: always able to take a word out of reset
    assign busy        = !i_rst_n;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign in_lane[0] = i_lane0_in;
    assign in_lane[1] = i_lane1_in;
    assign in_lane[2] = i_lane2_in;
    assign in_lane[3] = i_lane3_in;
    assign in_lane[4] = i_lane4_in;
    assign in_lane[5] = i_lane5_in;
    assign in_lane[6] = i_lane6_in;
    assign in_lane[7] = i_lane7_in;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ffrc_pkg::MODE_COPY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_row_end <= i_row_end_in;
            for (int k = 0; k < ffrc_pkg::LANE_COUNT; k++) begin
                r_in_lane[k] <= in_lane[k];
            end
        end
    end

    // Per-lane conversion
    for (genvar g = 0; g < ffrc_pkg::LANE_COUNT; g++) begin : g_lane
        ffrc_lane_conv u_conv (
            .i_mode (r_mode),
            .i_lane (r_in_lane[g]),
            .o_lane (n_res_lane[g])
        );
    end

    // Result register, shown for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_res_row_end <= r_in_row_end;
            for (int k = 0; k < ffrc_pkg::LANE_COUNT; k++) begin
                r_res_lane[k] <= n_res_lane[k];
            end
        end
    end

    assign o_done        = r_res_vld;
    assign o_row_end_out = r_res_row_end;
    assign o_lane0_out   = r_res_lane[0];
    assign o_lane1_out   = r_res_lane[1];
    assign o_lane2_out   = r_res_lane[2];
    assign o_lane3_out   = r_res_lane[3];
    assign o_lane4_out   = r_res_lane[4];
    assign o_lane5_out   = r_res_lane[5];
    assign o_lane6_out   = r_res_lane[6];
    assign o_lane7_out   = r_res_lane[7];

    // Every strobe traces back to an accepted word, through the input and result registers
    a_done_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 2))
        else $error("result strobe without an accepted word");

    // Row-end mark follows its word through the result stage
    a_row_end_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> (o_row_end_out == $past(r_in_row_end)))
        else $error("row-end mark lost between stages");

    // Copy mode passes lane 0 unchanged
    a_copy_lane0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_mode == ffrc_pkg::MODE_COPY) |=>
        (o_lane0_out == $past(r_in_lane[0])))
        else $error("copy mode altered lane 0");

    // fp16 to bf16 keeps a zero exponent at zero
    a_bf16_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_mode == ffrc_pkg::MODE_FP16_BF16 && r_in_lane[0][14:10] == 5'd0)
        |=> (o_lane0_out[14:7] == 8'd0))
        else $error("zero fp16 exponent was rebiased");

endmodule

// ===== hw/rtl/ffrc_lane_conv.sv =====
// One lane of the format converter: mask, shift, add and compare logic only.
module ffrc_lane_conv (
    input  logic [ffrc_pkg::MODE_W-1:0] i_mode,
    input  ffrc_pkg::t_lane             i_lane,
    output ffrc_pkg::t_lane             o_lane
);

    // Pack sign, 8-bit biased exponent and 10-bit mantissa into fp16:
    // flush small exponents to signed zero, clamp large ones to sign | 0x7fff
    function automatic logic [15:0] to_fp16(input logic       sign,
                                            input logic [7:0] exp8,
                                            input logic [9:0] mant10);
        logic [7:0] exp_rb;
        exp_rb = exp8 - ffrc_pkg::EXP_REBIAS;
        if (exp8 <= ffrc_pkg::EXP_REBIAS) begin
            to_fp16 = {sign, 15'h0000};
        end else if (exp8 > ffrc_pkg::EXP_SRC_MAX) begin
            to_fp16 = {sign, 15'h7fff};
        end else begin
            to_fp16 = {sign, exp_rb[4:0], mant10};
        end
    endfunction

    logic [15:0] half;
    logic [7:0]  bf_exp;

    assign half = i_lane[15:0];

    // fp16 -> bf16 exponent: zero stays zero, anything else gains 112
    assign bf_exp = (half[14:10] == 5'd0) ? 8'd0
                                          : ({3'b000, half[14:10]} + ffrc_pkg::EXP_REBIAS);

    always_comb begin
        case (i_mode)
            ffrc_pkg::MODE_F32_BF16: begin
                o_lane = {16'h0000, i_lane[31:16]};
            end
            ffrc_pkg::MODE_F32_FP16: begin
                o_lane = {16'h0000, to_fp16(i_lane[31], i_lane[30:23], i_lane[22:13])};
            end
            ffrc_pkg::MODE_BF16_FP16: begin
                o_lane = {16'h0000, to_fp16(half[15], half[14:7], {half[6:0], 3'b000})};
            end
            ffrc_pkg::MODE_FP16_BF16: begin
                o_lane = {16'h0000, half[15], bf_exp, half[9:3]};
            end
            default: begin
                o_lane = i_lane;
            end
        endcase
    end

endmodule

// ===== sim/float_format_row_converter_test.sv =====
`timescale 1ns / 1ps

module float_format_row_converter_test;

    // Mode codes with no name in the package; the block treats them as copy
    localparam logic [ffrc_pkg::MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
    localparam logic [ffrc_pkg::MODE_W-1:0] MODE_RSVD_LAST  = 3'd7;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int IDLE_PERCENT  = 19;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_WORDS   = 100;

    // Biased 8-bit exponents around the fp16 flush and clamp thresholds
    localparam logic [7:0] EXP_EDGES [8] = '{8'd0, 8'd112, 8'd113, 8'd127,
                                             8'd142, 8'd143, 8'd144, 8'd255};

    typedef logic [ffrc_pkg::LANE_COUNT-1:0][ffrc_pkg::LANE_W-1:0] t_row_lanes;

    typedef struct packed {
        t_row_lanes lanes;
        logic       row_end;
    } t_row;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        start        = 1'b0;
    logic                        i_cfg_valid  = 1'b0;
    logic [ffrc_pkg::MODE_W-1:0] i_cfg_data   = '0;
    t_row_lanes                  drv_lanes    = '0;
    logic                        drv_row_end  = 1'b0;

    logic                        busy;
    logic                        o_done;
    logic                        o_row_end_out;
    logic                        o_cfg_ready;
    t_row_lanes                  got_lanes;

    logic [ffrc_pkg::MODE_W-1:0] cur_mode     = ffrc_pkg::MODE_COPY;
    bit                          idle_enable  = 1'b1;
    int                          fail_count   = 0;
    int                          cycle_count  = 0;
    t_row                        pending_rows [$];

    always #5 i_clk = ~i_clk;

    float_format_row_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_lane0_in    (drv_lanes[0]),
        .i_lane1_in    (drv_lanes[1]),
        .i_lane2_in    (drv_lanes[2]),
        .i_lane3_in    (drv_lanes[3]),
        .i_lane4_in    (drv_lanes[4]),
        .i_lane5_in    (drv_lanes[5]),
        .i_lane6_in    (drv_lanes[6]),
        .i_lane7_in    (drv_lanes[7]),
        .i_row_end_in  (drv_row_end),
        .o_done        (o_done),
        .o_lane0_out   (got_lanes[0]),
        .o_lane1_out   (got_lanes[1]),
        .o_lane2_out   (got_lanes[2]),
        .o_lane3_out   (got_lanes[3]),
        .o_lane4_out   (got_lanes[4]),
        .o_lane5_out   (got_lanes[5]),
        .o_lane6_out   (got_lanes[6]),
        .o_lane7_out   (got_lanes[7]),
        .o_row_end_out (o_row_end_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Build an fp16 value from an unbiased exponent: flush low, clamp high
    function automatic logic [15:0] pack_fp16(logic sign, int exp_unb, logic [9:0] mant);
        logic [4:0] exp_field;
        if (exp_unb <= -15) begin
            exp_unb = -15;
            mant    = '0;
        end
        if (exp_unb > 16) begin
            exp_unb = 16;
            mant    = '1;
        end
        exp_field = 5'(exp_unb + 15);
        return {sign, exp_field, mant};
    endfunction

    // Expected value of one lane under a given mode
    function automatic ffrc_pkg::t_lane convert_lane(logic [ffrc_pkg::MODE_W-1:0] mode,
                                                     ffrc_pkg::t_lane x);
        logic [7:0] bf_exp;
        case (mode)
            ffrc_pkg::MODE_F32_BF16: begin
                return {16'h0, x[31:16]};
            end
            ffrc_pkg::MODE_F32_FP16: begin
                return {16'h0, pack_fp16(x[31], int'(x[30:23]) - 127, x[22:13])};
            end
            ffrc_pkg::MODE_BF16_FP16: begin
                return {16'h0, pack_fp16(x[15], int'(x[14:7]) - 127, {x[6:0], 3'b000})};
            end
            ffrc_pkg::MODE_FP16_BF16: begin
                // zero exponent stays zero, everything else rebiased (31 -> 143)
                bf_exp = (x[14:10] == 5'd0) ? 8'd0 : 8'(x[14:10]) + ffrc_pkg::EXP_REBIAS;
                return {16'h0, x[15], bf_exp, x[9:3]};
            end
            default: begin
                return x;
            end
        endcase
    endfunction

    // Random lane, biased toward exponent boundaries of every source format
    function automatic ffrc_pkg::t_lane rand_lane();
        ffrc_pkg::t_lane v;
        v = $urandom;
        case ($urandom_range(3, 0))
            0: ;
            1: v[30:23] = EXP_EDGES[$urandom_range(7, 0)];
            2: v[14:7]  = EXP_EDGES[$urandom_range(7, 0)];
            default: begin
                case ($urandom_range(3, 0))
                    0: v[14:10] = 5'd0;
                    1: v[14:10] = 5'd31;
                    2: v[14:10] = 5'd1;
                    default: ;
                endcase
            end
        endcase
        return v;
    endfunction

    // Send one word; record its expected result at the accepting edge
    task automatic send_row(input t_row_lanes lanes, input logic row_end);
        t_row want;
        // each cycle idles with the given odds
        while (idle_enable && $urandom_range(99, 0) < IDLE_PERCENT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        drv_lanes   <= lanes;
        drv_row_end <= row_end;
        do @(posedge i_clk); while (busy);
        for (int k = 0; k < ffrc_pkg::LANE_COUNT; k++)
            want.lanes[k] = convert_lane(cur_mode, lanes[k]);
        want.row_end = row_end;
        pending_rows.push_back(want);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rows.size() != 0);
    endtask

    // Mode write, only with the pipeline empty
    task automatic write_mode(input logic [ffrc_pkg::MODE_W-1:0] mode);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_mode    = mode;
        i_cfg_valid <= 1'b0;
    endtask

    // Mode after reset is copy; field extremes and both row-end values
    task automatic test_reset_copy();
        send_row('0, 1'b0);
        send_row('1, 1'b1);
        send_row({ffrc_pkg::LANE_COUNT{32'h8000_0000}}, 1'b0);
        send_row({ffrc_pkg::LANE_COUNT{32'h7fff_ffff}}, 1'b1);
    endtask

    task automatic test_fp32_bf16();
        write_mode(ffrc_pkg::MODE_F32_BF16);
        send_row({32'hffff_ffff, 32'h8000_0000, 32'h7f80_0001, 32'h0000_ffff,
                  32'h3f80_0000, 32'h1234_5678, 32'h0001_0000, 32'h0000_0000}, 1'b1);
    endtask

    // Flush at exponent -15, smallest normal, largest normal, clamp, inf, nan
    task automatic test_fp32_fp16();
        write_mode(ffrc_pkg::MODE_F32_FP16);
        send_row({32'h7f80_0000, 32'hc800_0000, 32'h4780_0000, 32'h477f_e000,
                  32'h3880_0000, 32'h3800_0000, 32'h8000_0000, 32'h0000_0000}, 1'b0);
        send_row({32'hffff_ffff, 32'h477f_ffff, 32'h3f80_1fff, 32'hbfff_ffff,
                  32'h3f80_0000, 32'hff80_0000, 32'h007f_ffff, 32'h7fc0_0001}, 1'b1);
    endtask

    // Same thresholds from the low half; the upper half must be ignored
    task automatic test_bf16_fp16();
        write_mode(ffrc_pkg::MODE_BF16_FP16);
        send_row({32'h0000_7f80, 32'h0000_c800, 32'h0000_4780, 32'h0000_477f,
                  32'h0000_3880, 32'h0000_3800, 32'h0000_8000, 32'h0000_0000}, 1'b0);
        send_row({32'hffff_ffff, 32'hdead_3f80, 32'hffff_007f, 32'h1234_ff81,
                  32'ha5a5_bfff, 32'h5a5a_47ff, 32'hffff_0000, 32'h8000_7fc1}, 1'b1);
    endtask

    // Zero exponent keeps its mantissa, exponent 31 rebiased like any other
    task automatic test_fp16_bf16();
        write_mode(ffrc_pkg::MODE_FP16_BF16);
        send_row({32'h0000_3c00, 32'h0000_7fff, 32'h0000_fc00, 32'h0000_7c00,
                  32'h0000_0400, 32'h0000_8001, 32'h0000_03ff, 32'h0000_0000}, 1'b0);
        send_row({32'hffff_ffff, 32'hffff_0000, 32'hdead_beef, 32'h8000_7bff,
                  32'h7fff_8400, 32'h1234_0007, 32'hffff_83ff, 32'hcafe_5555}, 1'b1);
    endtask

    // Unnamed mode codes behave as copy
    task automatic test_unused_modes();
        for (logic [ffrc_pkg::MODE_W:0] m = {1'b0, MODE_RSVD_FIRST};
             m <= {1'b0, MODE_RSVD_LAST}; m++) begin
            write_mode(m[ffrc_pkg::MODE_W-1:0]);
            send_row({ffrc_pkg::LANE_COUNT{32'h3f80_1234 ^ 32'(m)}}, m[0]);
        end
    endtask

    // Random words in phases: copy, code 7, then random modes; two phases send without idles
    task automatic test_random_rows();
        t_row_lanes                  lanes;
        logic [ffrc_pkg::MODE_W-1:0] mode;
        int unsigned                 pick;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                mode = ffrc_pkg::MODE_COPY;
            end else if (p == 1) begin
                mode = MODE_RSVD_LAST;
            end else begin
                pick = $urandom_range(MODE_RSVD_LAST, ffrc_pkg::MODE_COPY);
                mode = pick[ffrc_pkg::MODE_W-1:0];
            end
            write_mode(mode);
            idle_enable = !(p == 5 || p == 6);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                for (int k = 0; k < ffrc_pkg::LANE_COUNT; k++)
                    lanes[k] = rand_lane();
                send_row(lanes, 1'($urandom));
                if ($urandom_range(59, 0) == 0)
                    wait_drained();
            end
        end
        idle_enable = 1'b1;
    endtask

    // Result checker: every strobed word is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_row want;
        if (i_rst_n && o_done) begin
            if (pending_rows.size() == 0) begin
                $error("result word with no expectation pending");
                fail_count++;
            end else begin
                want = pending_rows.pop_front();
                for (int k = 0; k < ffrc_pkg::LANE_COUNT; k++) begin
                    if (got_lanes[k] !== want.lanes[k]) begin
                        $error("lane%0d_out: expected %h, actual %h",
                               k, want.lanes[k], got_lanes[k]);
                        fail_count++;
                    end
                end
                if (o_row_end_out !== want.row_end) begin
                    $error("row_end_out: expected %b, actual %b",
                           want.row_end, o_row_end_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("float_format_row_converter_test failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_copy();
        test_fp32_bf16();
        test_fp32_fp16();
        test_bf16_fp16();
        test_fp16_bf16();
        test_unused_modes();
        test_random_rows();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("float_format_row_converter_test passed");
        else
            $display("float_format_row_converter_test failed");
        $finish;
    end

endmodule
